// ----- design/sed_pkg.sv -----
// Shared types, character codes and helper functions for the string escape decoder.
// Depends on nothing; every other design file uses it.
`default_nettype none

package sed_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      STATUS_BYTE  = 2'd0,
      STATUS_CLOSE = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // Work handed from the front to the back through the queue.
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_ERROR = 2'd2,
      CMD_UNIT  = 2'd3
   } cmd_kind_type;

   typedef logic [15:0] unit_type;
   typedef logic [1:0]  count_type;    // result words per command, 1..3

   typedef struct packed {
      cmd_kind_type kind;
      unit_type     data;               // byte in [7:0], or the full code unit
      count_type    len;
   } cmd_type;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   localparam byte_type CH_BACKSLASH = 8'h5C;
   localparam byte_type CH_QUOTE     = 8'h22;
   localparam byte_type CH_N         = 8'h6E;
   localparam byte_type CH_R         = 8'h72;
   localparam byte_type CH_T         = 8'h74;
   localparam byte_type CH_U         = 8'h75;
   localparam byte_type CH_LF        = 8'h0A;
   localparam byte_type CH_CR        = 8'h0D;
   localparam byte_type CH_TAB       = 8'h09;

   localparam logic [2:0] HEX_DIGITS = 3'd4;
   localparam unit_type   UTF8_TWO_MIN   = 16'h0080;
   localparam unit_type   UTF8_THREE_MIN = 16'h0800;

   localparam byte_type UTF8_LEAD2 = 8'hC0;
   localparam byte_type UTF8_LEAD3 = 8'hE0;
   localparam byte_type UTF8_CONT  = 8'h80;

   // Bit 4 set flags a byte that is no hex digit; bits 3:0 hold the digit.
   function automatic logic [4:0] hex_value(input byte_type b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = {1'b0, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = {1'b0, 4'(b - 8'h37)};
      end
      return v;
   endfunction

   function automatic count_type utf8_len(input unit_type cu);
      count_type n;
      if (cu < UTF8_TWO_MIN) begin
         n = 2'd1;
      end else if (cu < UTF8_THREE_MIN) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- design/sed_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on sed_pkg for the payload types.
`default_nettype none

interface sed_req_if;
   logic               valid;
   logic               ready;
   sed_pkg::byte_type  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sed_rsp_if;
   logic                valid;
   logic                ready;
   sed_pkg::byte_type   out_byte;
   sed_pkg::status_type status;
   logic                last;

   modport source (output valid, output out_byte, output status, output last, input ready);
   modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// ----- design/sed_front.sv -----
// Front end: accepts raw string bytes, tracks escape state and classifies each byte.
// Depends on sed_pkg and sed_req_if; pushes commands into sed_fifo.
`default_nettype none

module sed_front (
   input  wire logic            clock,
   input  wire logic            reset,
   sed_req_if.sink              req,
   input  wire logic            full_i,
   output logic                 push_o,
   output sed_pkg::cmd_type     cmd_o
);
   import sed_pkg::*;

   logic        escape_pending_ff, escape_pending_in;
   logic [2:0]  hex_cnt_ff, hex_cnt_in;
   logic [11:0] accum_ff, accum_in;
   logic        accept;
   logic [4:0]  hex;
   unit_type    cu;

   assign req.ready = !full_i;
   assign accept    = req.valid && !full_i;
   assign hex       = hex_value(req.in_byte);
   assign cu        = {accum_ff, hex[3:0]};

   always_comb begin
      escape_pending_in = escape_pending_ff;
      hex_cnt_in        = hex_cnt_ff;
      accum_in          = accum_ff;
      push_o            = 1'b0;
      cmd_o.kind        = CMD_BYTE;
      cmd_o.data        = {8'h00, req.in_byte};
      cmd_o.len         = 2'd1;
      if (accept) begin
         if (hex_cnt_ff >= 3'd1 && hex_cnt_ff <= HEX_DIGITS) begin
            if (hex[4]) begin
               // drop the escape on a bad digit
               escape_pending_in = 1'b0;
               hex_cnt_in        = 3'd0;
               accum_in          = 12'h000;
               push_o            = 1'b1;
               cmd_o.kind        = CMD_ERROR;
            end else if (hex_cnt_ff < HEX_DIGITS) begin
               accum_in   = {accum_ff[7:0], hex[3:0]};
               hex_cnt_in = hex_cnt_ff + 3'd1;
            end else begin
               escape_pending_in = 1'b0;
               hex_cnt_in        = 3'd0;
               accum_in          = 12'h000;
               push_o            = 1'b1;
               cmd_o.kind        = CMD_UNIT;
               cmd_o.data        = cu;
               cmd_o.len         = utf8_len(cu);
            end
         end else if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            hex_cnt_in        = 3'd0;
            push_o            = 1'b1;
            unique case (req.in_byte)
               CH_BACKSLASH: cmd_o.data = {8'h00, CH_BACKSLASH};
               CH_QUOTE:     cmd_o.data = {8'h00, CH_QUOTE};
               CH_N:         cmd_o.data = {8'h00, CH_LF};
               CH_R:         cmd_o.data = {8'h00, CH_CR};
               CH_T:         cmd_o.data = {8'h00, CH_TAB};
               CH_U: begin
                  push_o     = 1'b0;
                  hex_cnt_in = 3'd1;
                  accum_in   = 12'h000;
               end
               default: begin
                  accum_in   = 12'h000;
                  cmd_o.kind = CMD_ERROR;
               end
            endcase
         end else begin
            hex_cnt_in = 3'd0;
            if (req.in_byte == CH_BACKSLASH) begin
               escape_pending_in = 1'b1;
            end else if (req.in_byte == CH_QUOTE) begin
               accum_in   = 12'h000;
               push_o     = 1'b1;
               cmd_o.kind = CMD_CLOSE;
            end else begin
               push_o = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         hex_cnt_ff        <= 3'd0;
         accum_ff          <= 12'h000;
      end else begin
         escape_pending_ff <= escape_pending_in;
         hex_cnt_ff        <= hex_cnt_in;
         accum_ff          <= accum_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sed_fifo.sv -----
// Short command queue between the front and the back end.
// Depends on sed_pkg for the command type and depth.
`default_nettype none

module sed_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_i,
   input  sed_pkg::cmd_type       cmd_i,
   input  wire logic              pop_i,
   output sed_pkg::cmd_type       head_o,
   output sed_pkg::fifo_stat_type stat_o
);
   import sed_pkg::*;

   cmd_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat_o.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign stat_o.empty = (count_ff == '0);
   assign do_push      = push_i && !stat_o.full;
   assign do_pop       = pop_i && !stat_o.empty;
   assign head_o       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cmd_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sed_back.sv -----
// Back end: expands queued commands into result words, UTF-8 one byte per cycle while rsp ready holds.
// Depends on sed_pkg and sed_rsp_if; reads the head of sed_fifo.
`default_nettype none

module sed_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  sed_pkg::cmd_type       head_i,
   input  sed_pkg::fifo_stat_type stat_i,
   output logic                   pop_o,
   sed_rsp_if.source              rsp
);
   import sed_pkg::*;

   logic       valid_ff, valid_in;
   byte_type   out_byte_ff, out_byte_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;
   count_type  idx_ff, idx_in;
   logic       load;
   byte_type   res_byte;
   status_type res_status;
   logic       res_last;

   assign load = !stat_i.empty && (!valid_ff || rsp.ready);

   always_comb begin
      res_byte   = head_i.data[7:0];
      res_status = STATUS_BYTE;
      res_last   = 1'b1;
      unique case (head_i.kind)
         CMD_BYTE: ;
         CMD_CLOSE: begin
            res_byte   = '0;
            res_status = STATUS_CLOSE;
         end
         CMD_ERROR: begin
            res_byte   = '0;
            res_status = STATUS_ERROR;
         end
         CMD_UNIT: begin
            res_last = (idx_ff == head_i.len - 2'd1);
            if (head_i.len == 2'd2) begin
               res_byte = (idx_ff == 2'd0) ? (UTF8_LEAD2 | {3'b000, head_i.data[10:6]})
                                           : (UTF8_CONT | {2'b00, head_i.data[5:0]});
            end else if (head_i.len == 2'd3) begin
               if (idx_ff == 2'd0) begin
                  res_byte = UTF8_LEAD3 | {4'h0, head_i.data[15:12]};
               end else if (idx_ff == 2'd1) begin
                  res_byte = UTF8_CONT | {2'b00, head_i.data[11:6]};
               end else begin
                  res_byte = UTF8_CONT | {2'b00, head_i.data[5:0]};
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in    = valid_ff;
      out_byte_in = out_byte_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      pop_o       = 1'b0;
      if (load) begin
         valid_in    = 1'b1;
         out_byte_in = res_byte;
         status_in   = res_status;
         last_in     = res_last;
         if (res_last) begin
            pop_o  = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.status   = status_ff;
   assign rsp.last     = last_ff;

endmodule

`default_nettype wire

// ----- design/string_escape_decoder.sv -----
// Top level of the string escape decoder: front end, command queue and back end.
// Depends on sed_pkg, sed_if, sed_front, sed_fifo and sed_back.
//
//   channel | dir | handshake           | word
//   --------+-----+---------------------+----------------------------------
//   req_ch  | in  | valid/ready         | in_byte: one raw string body byte
//   rsp_ch  | out | valid/ready         | out_byte, status, last
//
// One byte is taken per cycle whenever the four-entry command queue has room;
// req ready does not look at rsp ready. A result word passes through the command
// queue and then the output register after its byte. The back end emits one word
// per cycle while rsp ready holds, so a \uXXXX escape yields three words there for
// code units at or above 0x800, against six input bytes. Reset (synchronous) clears
// the escape state, the queue and the output valid flag; a stalled rsp holds its word
// and backs up through the queue until req ready drops.
`default_nettype none

module string_escape_decoder (
   input  wire logic clock,
   input  wire logic reset,
   sed_req_if.sink   req_ch,
   sed_rsp_if.source rsp_ch
);
   import sed_pkg::*;

   logic          push;
   cmd_type       push_cmd;
   logic          pop;
   cmd_type       head;
   fifo_stat_type fifo_stat;

   // Classify each accepted byte and update the escape state.
   sed_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .full_i (fifo_stat.full),
      .push_o (push),
      .cmd_o  (push_cmd)
   );

   // Decouple the two sides so a stalled output does not stop intake at once.
   sed_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .cmd_i  (push_cmd),
      .pop_i  (pop),
      .head_o (head),
      .stat_o (fifo_stat)
   );

   // Expand each command into one to three result words.
   sed_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head_i (head),
      .stat_i (fifo_stat),
      .pop_o  (pop),
      .rsp    (rsp_ch)
   );

   // The front never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_stat.full)
      else $error("command pushed into a full queue");

   // With nothing queued, nothing pushed and no word pending, no word appears.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_ch.valid && fifo_stat.empty && !push) |=> !rsp_ch.valid)
      else $error("result word without a queued command");

   // Close and error words end their input's results and carry a zero byte.
   a_ctrl_word_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_BYTE)
         |-> (rsp_ch.last && rsp_ch.out_byte == 8'h00))
      else $error("close or error word malformed");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for string_escape_decoder: directed and random string bodies,
// predicted results, random idling on both channels, long receiver stall and drain pause.
// Depends on sed_pkg, sed_if and the string_escape_decoder design files.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sed_pkg::*;

   localparam int HOLD_CYCLES = 300;  // long receiver stall, far beyond the queue depth
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 10;   // idle slack after the last word has come back

   // one decoded result word as it appears on the response channel
   typedef struct packed {
      byte_type   out_byte;
      status_type status;
      logic       last;
   } rsp_word_type;

   logic clock;
   logic reset;

   sed_req_if req_ch ();
   sed_rsp_if rsp_ch ();

   string_escape_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Decoder state mirror: escape seen, hex digit counter (0 = outside a
   // \u escape, n = n-1 digits taken), and the digits taken so far.
   logic        esc_armed;
   logic [2:0]  hex_count;
   logic [11:0] unit_acc;

   rsp_word_type expected_words[$];

   int mismatches;
   int bytes_sent;
   int gap_max;       // longest sender gap between bursts; 0 streams back to back
   int burst_left;
   bit hold_req;      // ask the receiver for one long stall

   // --------------------------------------------------------------------
   // Clock and timeout
   // --------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

   // --------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------

   // Value of a hex digit, or -1 for any other byte.
   function automatic int digit_of(input byte_type b);
      if (b >= 8'h30 && b <= 8'h39) begin
         return int'(b) - 'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         return int'(b) - 'h61 + 10;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         return int'(b) - 'h41 + 10;
      end
      return -1;
   endfunction

   function automatic void push_word(input byte_type b, input status_type st, input logic lst);
      rsp_word_type w;
      w.out_byte = b;
      w.status   = st;
      w.last     = lst;
      expected_words.push_back(w);
   endfunction

   function automatic void clear_escape();
      esc_armed = 1'b0;
      hex_count = 3'd0;
      unit_acc  = 12'd0;
   endfunction

   // Encode one 16-bit code unit as UTF-8; surrogates go straight to three bytes.
   function automatic void push_utf8(input logic [15:0] cu);
      if (cu < 16'h0080) begin
         push_word(cu[7:0], STATUS_BYTE, 1'b1);
      end else if (cu < 16'h0800) begin
         push_word(UTF8_LEAD2 | {3'b000, cu[10:6]}, STATUS_BYTE, 1'b0);
         push_word(UTF8_CONT | {2'b00, cu[5:0]}, STATUS_BYTE, 1'b1);
      end else begin
         push_word(UTF8_LEAD3 | {4'b0000, cu[15:12]}, STATUS_BYTE, 1'b0);
         push_word(UTF8_CONT | {2'b00, cu[11:6]}, STATUS_BYTE, 1'b0);
         push_word(UTF8_CONT | {2'b00, cu[5:0]}, STATUS_BYTE, 1'b1);
      end
   endfunction

   // Advance the mirror by one accepted byte and queue the words it causes.
   function automatic void decode_byte(input byte_type b);
      int d;
      logic [15:0] cu;
      if (hex_count >= 3'd1 && hex_count <= HEX_DIGITS) begin
         d = digit_of(b);
         if (d < 0) begin
            clear_escape();
            push_word(8'h00, STATUS_ERROR, 1'b1);
         end else if (hex_count < HEX_DIGITS) begin
            unit_acc  = {unit_acc[7:0], 4'(d)};
            hex_count = hex_count + 3'd1;
         end else begin
            cu = {unit_acc, 4'(d)};
            clear_escape();
            push_utf8(cu);
         end
         return;
      end
      if (esc_armed) begin
         esc_armed = 1'b0;
         hex_count = 3'd0;
         case (b)
            CH_BACKSLASH: push_word(CH_BACKSLASH, STATUS_BYTE, 1'b1);
            CH_QUOTE:     push_word(CH_QUOTE, STATUS_BYTE, 1'b1);
            CH_N:         push_word(CH_LF, STATUS_BYTE, 1'b1);
            CH_R:         push_word(CH_CR, STATUS_BYTE, 1'b1);
            CH_T:         push_word(CH_TAB, STATUS_BYTE, 1'b1);
            CH_U: begin
               hex_count = 3'd1;
               unit_acc  = 12'd0;
            end
            default: begin
               clear_escape();
               push_word(8'h00, STATUS_ERROR, 1'b1);
            end
         endcase
         return;
      end
      hex_count = 3'd0;
      if (b == CH_BACKSLASH) begin
         esc_armed = 1'b1;
      end else if (b == CH_QUOTE) begin
         clear_escape();
         push_word(8'h00, STATUS_CLOSE, 1'b1);
      end else begin
         push_word(b, STATUS_BYTE, 1'b1);
      end
   endfunction

   // --------------------------------------------------------------------
   // Sender
   // --------------------------------------------------------------------

   // Offer one word and hold it until accepted. Bursts of random length are
   // separated by random idle gaps; within a burst valid stays high.
   task automatic send_byte(input byte_type b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   // Hex digit character; upper selects the case of a through f.
   function automatic byte_type hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) begin
         return 8'h30 + byte_type'(n);
      end
      return (upper ? 8'h41 : 8'h61) + byte_type'(n - 4'd10);
   endfunction

   // Send \uXXXX; each bit of case_sel picks the case of one digit.
   task automatic send_unicode(input logic [15:0] cu, input logic [3:0] case_sel);
      send_byte(CH_BACKSLASH);
      send_byte(CH_U);
      send_byte(hex_char(cu[15:12], case_sel[3]));
      send_byte(hex_char(cu[11:8], case_sel[2]));
      send_byte(hex_char(cu[7:4], case_sel[1]));
      send_byte(hex_char(cu[3:0], case_sel[0]));
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // --------------------------------------------------------------------
   // Receiver: ready follows a stall probability that changes from phase to
   // phase (zero included), plus one long stall on request.
   // --------------------------------------------------------------------
   initial begin
      int stall_pct;
      int phase_left;
      int hold_left;
      stall_pct  = 0;
      phase_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (phase_left == 0) begin
            case ($urandom_range(3, 0))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
            phase_left = $urandom_range(80, 20);
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   // --------------------------------------------------------------------
   // Checker: compare each accepted word with the oldest prediction.
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word out_byte=%h status=%0d last=%b", $time,
                     rsp_ch.out_byte, rsp_ch.status, rsp_ch.last);
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_ch.out_byte !== exp_w.out_byte) begin
               mismatches++;
               $display("%0t: out_byte expected %h actual %h", $time,
                        exp_w.out_byte, rsp_ch.out_byte);
            end
            if (rsp_ch.status !== exp_w.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_w.status, rsp_ch.status);
            end
            if (rsp_ch.last !== exp_w.last) begin
               mismatches++;
               $display("%0t: last expected %b actual %b", $time, exp_w.last, rsp_ch.last);
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // Extremes of the byte range pass through; a bare quote closes.
   task automatic test_plain_bytes();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_QUOTE);
   endtask

   task automatic test_simple_escapes();
      send_byte(CH_BACKSLASH); send_byte(CH_BACKSLASH);
      send_byte(CH_BACKSLASH); send_byte(CH_QUOTE);
      send_byte(CH_BACKSLASH); send_byte(CH_N);
      send_byte(CH_BACKSLASH); send_byte(CH_R);
      send_byte(CH_BACKSLASH); send_byte(CH_T);
   endtask

   // Unknown escape letter, then a non-hex byte inside a \u escape.
   task automatic test_escape_errors();
      send_byte(CH_BACKSLASH); send_byte(8'h71);
      send_byte(CH_BACKSLASH); send_byte(CH_U); send_byte(8'h67);
   endtask

   // Code unit zero gives one 0x00 byte; a surrogate with mixed-case digits
   // goes out as three bytes with no pairing.
   task automatic test_unicode_escapes();
      send_unicode(16'h0000, 4'b0000);
      send_unicode(16'hDBFF, 4'b0101);
   endtask

   // Mostly well-formed string bodies with random content; some noise and
   // broken escapes mixed in.
   task automatic test_random_strings(input int n_bytes);
      int start;
      int pick;
      int k;
      byte_type b;
      logic [15:0] cu;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            send_byte(byte_type'($urandom_range(255, 0)));
         end else if (pick < 55) begin
            send_byte(CH_BACKSLASH);
            case ($urandom_range(4, 0))
               0: send_byte(CH_BACKSLASH);
               1: send_byte(CH_QUOTE);
               2: send_byte(CH_N);
               3: send_byte(CH_R);
               default: send_byte(CH_T);
            endcase
         end else if (pick < 80) begin
            // spread code units over every UTF-8 length and the surrogate range
            case ($urandom_range(3, 0))
               0: cu = 16'($urandom_range('h7F, 0));
               1: cu = 16'($urandom_range('h7FF, 'h80));
               2: cu = 16'($urandom_range('hFFFF, 'h800));
               default: cu = 16'($urandom_range('hDFFF, 'hD800));
            endcase
            send_unicode(cu, 4'($urandom_range(15, 0)));
         end else if (pick < 86) begin
            send_byte(CH_QUOTE);
         end else if (pick < 92) begin
            do begin
               b = byte_type'($urandom_range(255, 0));
            end while (b == CH_BACKSLASH || b == CH_QUOTE || b == CH_N || b == CH_R ||
                       b == CH_T || b == CH_U);
            send_byte(CH_BACKSLASH);
            send_byte(b);
         end else begin
            // cut a \u escape short with a non-hex byte after 0..3 digits
            send_byte(CH_BACKSLASH);
            send_byte(CH_U);
            k = $urandom_range(3, 0);
            repeat (k) send_byte(hex_char(4'($urandom_range(15, 0)), 1'($urandom)));
            do begin
               b = byte_type'($urandom_range(255, 0));
            end while (digit_of(b) >= 0);
            send_byte(b);
         end
      end
   endtask

   // Stall the receiver for a long stretch while the sender streams
   // without gaps, so the command queue fills and req ready drops.
   task automatic test_backpressure();
      gap_max  = 0;
      hold_req = 1'b1;
      test_random_strings(60);
   endtask

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      int guard;
      mismatches = 0;
      bytes_sent = 0;
      burst_left = 0;
      gap_max    = 3;
      hold_req   = 1'b0;
      clear_escape();
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_bytes();
      test_simple_escapes();
      test_escape_errors();
      test_unicode_escapes();
      pause_until_drained();

      gap_max = 4;
      test_random_strings(130);
      pause_until_drained();

      test_backpressure();

      gap_max = 0;
      test_random_strings(80);
      gap_max = 6;
      test_random_strings(80);

      // hold valid low, then wait for the last words to come back
      req_ch.valid <= 1'b0;
      guard = 0;
      while (expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (expected_words.size() != 0) begin
         mismatches += expected_words.size();
         $display("%0t: %0d expected words never arrived, first expected %h", $time,
                  expected_words.size(), expected_words[0]);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
